FILE: rtl/smat_pkg.sv
// Shared types and constants for the stereo mix accumulate engine.
`timescale 1ns / 1ps

package smat_pkg;

	// item kinds
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_MIX16 = 2'd1,
		KIND_MIX8  = 2'd2,
		KIND_DRAIN = 2'd3
	} kind_t;

	// register word indexes on the config port
	localparam logic [1:0] REG_MASTER = 2'd0;
	localparam logic [1:0] REG_OUT8   = 2'd1;
	localparam logic [1:0] REG_STEREO = 2'd2;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 19;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// accumulator and sample widths
	localparam int ACC_W = 32;
	localparam int SMP_W = 16;

	// operand pair handed to the shared multiplier
	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

FILE: rtl/smat_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module smat_mul (
	input  logic                                clk,
	input  smat_pkg::mul_req_t                  req,
	output logic signed [smat_pkg::MUL_P_W-1:0] prod
);
	import smat_pkg::*;

	logic signed [MUL_P_W-1:0] prod_q;

	// one product per cycle, held in a register
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(req.a * req.b);
	end

	assign prod = prod_q;

endmodule

FILE: rtl/smat_mem.sv
// Mix buffer memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module smat_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [2*smat_pkg::ACC_W-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [2*smat_pkg::ACC_W-1:0] rdata
);
	import smat_pkg::*;

	logic [2*ACC_W-1:0] mem [DEPTH];
	logic [2*ACC_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/stereo_mix_accumulate_transfer.sv
// Top level: sequencer, config registers and output register of the mix engine.
//
//  channel  | handshake              | word
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | kind, frame_index, sample, gains, load values
//  output   | out_valid / out_stall  | ring_position, out_sample, last
//  config   | psel/penable/pready    | paddr, pwdata, prdata
//
// Load writes the buffer directly; mix16 and mix8 read the buffer, make four passes through
// the one shared multiplier and write the buffer back; drain reads the buffer and emits one
// or two words, waiting out any output stall. After reset a clearing pass writes zero to all
// MIX_FRAMES frames, one per cycle; in_stall stays high until it ends. A stalled output word
// holds in the output register; the block goes idle once the last word of a drain is registered.
`timescale 1ns / 1ps

module stereo_mix_accumulate_transfer #(
	parameter int MIX_FRAMES   = 2048,
	parameter int RING_SAMPLES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [10:0]        frame_index,
	input  logic signed [15:0] sample,
	input  logic [7:0]         left_gain,
	input  logic [7:0]         right_gain,
	input  logic signed [31:0] load_left,
	input  logic signed [31:0] load_right,
	// output words
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        ring_position,
	output logic signed [15:0] out_sample,
	output logic               last,
	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import smat_pkg::*;

	localparam int FRAME_W = $clog2(MIX_FRAMES);
	localparam int RING_W  = $clog2(RING_SAMPLES);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_ML_GAIN,
		S_ML_SMP,
		S_MR_GAIN,
		S_MR_SMP,
		S_WRITE,
		S_EMIT_L,
		S_EMIT_R
	} state_t;

	state_t                   state_q;
	logic [FRAME_W-1:0]       clr_q;
	logic [FRAME_W-1:0]       frame_q;
	kind_t                    kind_q;
	logic signed [15:0]       sample_q;
	logic [7:0]               gain_l_q;
	logic [7:0]               gain_r_q;
	logic [ACC_W-1:0]         acc_l_q;
	logic [ACC_W-1:0]         load_r_q;
	logic [RING_W-1:0]        ring_q;
	logic                     out_valid_q;
	logic [11:0]              ring_pos_q;
	logic [SMP_W-1:0]         out_sample_q;
	logic                     last_q;

	logic [9:0]               master_q;
	logic                     out8_q;
	logic                     stereo_q;

	logic [FRAME_W-1:0]       frame_mod;
	logic                     accept;
	logic                     out_free;
	logic                     emit_go;
	logic [RING_W-1:0]        ring_next;
	mul_req_t                 mul_req;
	logic signed [MUL_P_W-1:0] prod;
	logic                     mem_we;
	logic [FRAME_W-1:0]       mem_waddr;
	logic [2*ACC_W-1:0]       mem_wdata;
	logic                     mem_re;
	logic [2*ACC_W-1:0]       mem_rdata;
	logic [ACC_W-1:0]         rd_l;
	logic [ACC_W-1:0]         rd_r;
	logic [ACC_W-1:0]         addend;
	logic [7:0]               gain_sel;
	logic [SMP_W-1:0]         drain_l;
	logic [SMP_W-1:0]         drain_r;

	// config registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= 10'd256;
			out8_q   <= 1'b0;
			stereo_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_MASTER: master_q <= pwdata[9:0];
				REG_OUT8:   out8_q   <= pwdata[0];
				REG_STEREO: stereo_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MASTER: prdata = {22'd0, master_q};
			REG_OUT8:   prdata = {31'd0, out8_q};
			REG_STEREO: prdata = {31'd0, stereo_q};
			default:    prdata = 32'd0;
		endcase
	end

	// frame index modulo MIX_FRAMES by restoring subtraction of shifted divisors
	always_comb begin
		logic [23:0] r;
		r = 24'(frame_index);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (24'(MIX_FRAMES) << k)) begin
				r = r - (24'(MIX_FRAMES) << k);
			end
		end
		frame_mod = FRAME_W'(r);
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign ring_next = (ring_q == RING_W'(RING_SAMPLES - 1)) ? '0 : ring_q + 1'b1;

	// a new output word is registered this cycle
	assign emit_go = (state_q inside {S_EMIT_L, S_EMIT_R}) && out_free;

	assign rd_l = mem_rdata[ACC_W-1:0];
	assign rd_r = mem_rdata[2*ACC_W-1:ACC_W];

	// scaled product to accumulator addend, wrapped to 32 bits
	assign addend = (kind_q == KIND_MIX8) ? {prod[28:0], 3'b000}
	                                      : {{4{prod[MUL_P_W-1]}}, prod[MUL_P_W-1:8]};

	// shared multiplier operands: gain times master, then that times the sample
	always_comb begin
		gain_sel = (state_q == S_MR_GAIN) ? gain_r_q : gain_l_q;
		if (kind_q == KIND_MIX8) begin
			gain_sel = {3'b000, gain_sel[7:3]};
		end
		mul_req.a = prod[MUL_A_W-1:0];
		if (kind_q == KIND_MIX8) begin
			mul_req.b = {{9{sample_q[7]}}, sample_q[7:0]};
		end else begin
			mul_req.b = {sample_q[15], sample_q};
		end
		if (state_q == S_READ || state_q == S_MR_GAIN) begin
			mul_req.a = {11'd0, gain_sel};
			mul_req.b = {7'd0, master_q};
		end
	end

	smat_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// buffer port control
	always_comb begin
		mem_re    = (state_q == S_READ);
		mem_we    = 1'b0;
		mem_waddr = frame_q;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (state_q == S_WRITE) begin
			mem_we = 1'b1;
			if (kind_q == KIND_LOAD) begin
				mem_wdata = {load_r_q, acc_l_q};
			end else begin
				mem_wdata = {rd_r + addend, acc_l_q};
			end
		end
	end

	smat_mem #(
		.DEPTH (MIX_FRAMES),
		.AW    (FRAME_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (frame_q),
		.rdata (mem_rdata)
	);

	// drain: shift right 8, saturate to 16 bits, optional offset 8-bit form
	function automatic logic [SMP_W-1:0] drain_fmt(input logic [ACC_W-1:0] acc,
	                                              input logic out8);
		logic [SMP_W-1:0] sat;
		if (acc[31:23] == 9'h000 || acc[31:23] == 9'h1ff) begin
			sat = acc[23:8];
		end else if (acc[31]) begin
			sat = 16'h8000;
		end else begin
			sat = 16'h7fff;
		end
		if (out8) begin
			return {8'd0, ~sat[15], sat[14:8]};
		end
		return sat;
	endfunction

	assign drain_l = drain_fmt(rd_l, out8_q);
	assign drain_r = drain_fmt(rd_r, out8_q);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			frame_q      <= '0;
			kind_q       <= KIND_LOAD;
			sample_q     <= '0;
			gain_l_q     <= '0;
			gain_r_q     <= '0;
			acc_l_q      <= '0;
			load_r_q     <= '0;
			ring_q       <= '0;
			out_valid_q  <= 1'b0;
			ring_pos_q   <= '0;
			out_sample_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FRAME_W'(MIX_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						frame_q  <= frame_mod;
						kind_q   <= kind_t'(kind);
						sample_q <= sample;
						gain_l_q <= left_gain;
						gain_r_q <= right_gain;
						acc_l_q  <= load_left;
						load_r_q <= load_right;
						state_q  <= (kind_t'(kind) == KIND_LOAD) ? S_WRITE : S_READ;
					end
				end
				S_READ: begin
					state_q <= (kind_q == KIND_DRAIN) ? S_EMIT_L : S_ML_GAIN;
				end
				S_ML_GAIN: state_q <= S_ML_SMP;
				S_ML_SMP: begin
					acc_l_q <= rd_l + addend;
					state_q <= S_MR_GAIN;
				end
				S_MR_GAIN: state_q <= S_MR_SMP;
				S_MR_SMP:  state_q <= S_WRITE;
				S_WRITE:   state_q <= S_IDLE;
				S_EMIT_L: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						ring_pos_q   <= 12'(ring_q);
						out_sample_q <= drain_l;
						last_q       <= !stereo_q;
						ring_q       <= ring_next;
						state_q      <= stereo_q ? S_EMIT_R : S_IDLE;
					end
				end
				S_EMIT_R: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						ring_pos_q   <= 12'(ring_q);
						out_sample_q <= drain_r;
						last_q       <= 1'b1;
						ring_q       <= ring_next;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign ring_position = ring_pos_q;
	assign out_sample    = out_sample_q;
	assign last          = last_q;

endmodule

FILE: tb/tb_stereo_mix_accumulate_transfer.sv
// Testbench for the stereo mix accumulate engine: scoreboard, drivers, stimulus and checks.
`timescale 1ns / 1ps

module tb_stereo_mix_accumulate_transfer;
	import smat_pkg::*;

	localparam int FRAMES      = 2048;
	localparam int IDLE_PCT    = 37;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_WORDS = 100;
	localparam int SWEEP_WORDS = 1150;

	// one input word and one output word
	typedef struct {
		kind_t              kind;
		logic [10:0]        frame;
		logic signed [15:0] smp;
		logic [7:0]         lg;
		logic [7:0]         rg;
		logic signed [31:0] ld_l;
		logic signed [31:0] ld_r;
	} mix_word_t;

	typedef struct {
		logic [11:0] pos;
		logic [15:0] smp;
		logic        last;
	} ring_word_t;

	// mirror of the mix buffer and ring pointer, plus the queue of awaited ring words
	class mix_scoreboard;
		logic [31:0] left_acc [FRAMES];
		logic [31:0] right_acc [FRAMES];
		logic [11:0] ring_ptr;
		logic [9:0]  master;
		logic        out8;
		logic        stereo;
		ring_word_t  awaited [$];
		int          errors;

		function void clear_all();
			foreach (left_acc[i]) begin
				left_acc[i] = '0;
				right_acc[i] = '0;
			end
			ring_ptr = '0;
			master = 10'd256;
			out8 = 1'b0;
			stereo = 1'b1;
			awaited.delete();
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_MASTER: master = val[9:0];
				REG_OUT8:   out8 = val[0];
				REG_STEREO: stereo = val[0];
				default: ;
			endcase
		endfunction

		// floor by 256, clamp to 16 bits, then optional offset 8-bit form
		function logic [15:0] drained(logic [31:0] acc);
			int v;
			v = int'(acc);
			v = v >>> 8;
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			if (out8)
				v = (v >>> 8) + 128;
			return v[15:0];
		endfunction

		function void emit_word(logic [15:0] v, logic lst);
			ring_word_t e;
			e.pos = ring_ptr;
			e.smp = v;
			e.last = lst;
			awaited.push_back(e);
			ring_ptr = ring_ptr + 12'd1;
		endfunction

		function void note_input(mix_word_t w);
			longint s;
			longint add_l;
			longint add_r;
			byte    b;
			int     f;
			f = w.frame;
			case (w.kind)
				KIND_LOAD: begin
					left_acc[f] = w.ld_l;
					right_acc[f] = w.ld_r;
				end
				KIND_MIX16: begin
					s = w.smp;
					add_l = (s * (longint'(w.lg) * longint'(master))) >>> 8;
					add_r = (s * (longint'(w.rg) * longint'(master))) >>> 8;
					left_acc[f] = left_acc[f] + add_l[31:0];
					right_acc[f] = right_acc[f] + add_r[31:0];
				end
				KIND_MIX8: begin
					// only the low byte counts, gain drops to 5 bits
					b = w.smp[7:0];
					s = b;
					add_l = s * longint'(w.lg >> 3) * 8 * longint'(master);
					add_r = s * longint'(w.rg >> 3) * 8 * longint'(master);
					left_acc[f] = left_acc[f] + add_l[31:0];
					right_acc[f] = right_acc[f] + add_r[31:0];
				end
				default: begin
					if (stereo) begin
						emit_word(drained(left_acc[f]), 1'b0);
						emit_word(drained(right_acc[f]), 1'b1);
					end else begin
						emit_word(drained(left_acc[f]), 1'b1);
					end
				end
			endcase
		endfunction

		function void check_result(logic [11:0] pos, logic [15:0] smp, logic lst);
			ring_word_t e;
			if (awaited.size() == 0) begin
				$error("ring word at position %0d with nothing awaited", pos);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (pos !== e.pos) begin
				$error("ring_position: expected %0d, actual %0d", e.pos, pos);
				errors++;
			end
			if (smp !== e.smp) begin
				$error("out_sample: expected %0d, actual %0d", $signed(e.smp), $signed(smp));
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	// block ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         kind = '0;
	logic [10:0]        frame_index = '0;
	logic signed [15:0] sample = '0;
	logic [7:0]         left_gain = '0;
	logic [7:0]         right_gain = '0;
	logic signed [31:0] load_left = '0;
	logic signed [31:0] load_right = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic [11:0]        ring_position;
	logic signed [15:0] out_sample;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// bench state
	mix_scoreboard sb;
	logic          calm = 1'b0;
	logic          hold_tog = 1'b0;
	logic          hold_seen = 1'b0;
	int            hold_left = 0;
	int            quiet = 0;
	int            words_sent = 0;
	logic [10:0]   frame_pool [8];

	stereo_mix_accumulate_transfer uut (.*);

	always #6 clk = ~clk;

	// output side: check accepted words, random stall, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(ring_position, out_sample, last);
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(int mv, bit o8, bit st);
		write_reg(REG_MASTER, mv);
		write_reg(REG_OUT8, o8);
		write_reg(REG_STEREO, st);
	endtask

	// input side: random gaps, hold the word until taken
	task automatic send_word(mix_word_t w);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= w.kind;
		frame_index <= w.frame;
		sample <= w.smp;
		left_gain <= w.lg;
		right_gain <= w.rg;
		load_left <= w.ld_l;
		load_right <= w.ld_r;
		do @(posedge clk); while (in_stall);
		sb.note_input(w);
		words_sent++;
	endtask

	// stop offering and wait until every awaited ring word is out, plus tail latency
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic mix_word_t mk(kind_t k, int f, int s, int lgv, int rgv, int ll, int lr);
		mix_word_t w;
		w.kind = k;
		w.frame = 11'(f);
		w.smp = 16'(s);
		w.lg = 8'(lgv);
		w.rg = 8'(rgv);
		w.ld_l = ll;
		w.ld_r = lr;
		return w;
	endfunction

	function automatic logic [7:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly a small pool so frames see several mixes before a drain
	function automatic logic [10:0] pick_frame();
		if ($urandom_range(0, 3) == 0)
			return 11'($urandom_range(0, FRAMES - 1));
		return frame_pool[$urandom_range(0, 7)];
	endfunction

	function automatic mix_word_t random_word(kind_t k, logic [10:0] f);
		mix_word_t w;
		w.kind = k;
		w.frame = f;
		w.smp = 16'($urandom);
		w.lg = pick_gain();
		w.rg = pick_gain();
		w.ld_l = signed'($urandom) >>> $urandom_range(0, 31);
		w.ld_r = signed'($urandom) >>> $urandom_range(0, 31);
		return w;
	endfunction

	initial begin
		int          target;
		logic [10:0] f;
		kind_t       mix_kind;

		sb = new;
		sb.clear_all();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		configure(256, 1'b0, 1'b1);

		// directed: saturation both ways, floor of negatives, byte read of mix8,
		// accumulator wrap, extreme frames
		send_word(mk(KIND_LOAD, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000));
		send_word(mk(KIND_DRAIN, 0, 0, 0, 0, 0, 0));
		send_word(mk(KIND_LOAD, 2047, 16'hffff, 255, 255, 255, -1));
		send_word(mk(KIND_DRAIN, 2047, 0, 0, 0, 0, 0));
		send_word(mk(KIND_MIX16, 1, -32768, 255, 0, 0, 0));
		send_word(mk(KIND_MIX16, 1, 32767, 0, 255, 0, 0));
		send_word(mk(KIND_DRAIN, 1, 0, 0, 0, 0, 0));
		send_word(mk(KIND_MIX8, 2, 16'h7f80, 255, 7, 0, 0));
		send_word(mk(KIND_MIX8, 2, 16'h807f, 8, 255, 0, 0));
		send_word(mk(KIND_DRAIN, 2, 0, 0, 0, 0, 0));
		send_word(mk(KIND_MIX16, 3, -1, 1, 1, 0, 0));
		send_word(mk(KIND_DRAIN, 3, 0, 0, 0, 0, 0));
		send_word(mk(KIND_LOAD, 4, 0, 0, 0, 32'h7fffff00, 32'hffff8000));
		send_word(mk(KIND_MIX16, 4, 32767, 255, 255, 0, 0));
		settle();

		// master above 512, 8-bit mono output
		configure(1023, 1'b1, 1'b0);
		send_word(mk(KIND_DRAIN, 4, 0, 0, 0, 0, 0));
		send_word(mk(KIND_LOAD, 5, 0, 0, 0, 32'h80000000, 0));
		send_word(mk(KIND_DRAIN, 5, 0, 0, 0, 0, 0));
		send_word(mk(KIND_LOAD, 6, 0, 0, 0, 32'h0000ffff, 32'h7fffffff));
		send_word(mk(KIND_DRAIN, 6, 0, 0, 0, 0, 0));
		send_word(mk(KIND_MIX8, 7, 16'h0080, 255, 255, 0, 0));
		send_word(mk(KIND_DRAIN, 7, 0, 0, 0, 0, 0));
		send_word(mk(KIND_MIX16, 7, -32768, 255, 255, 0, 0));
		send_word(mk(KIND_DRAIN, 7, 0, 0, 0, 0, 0));
		settle();

		// random phases: an optional load, a few mixes, then drains on one frame, with some noise
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(0, 1'b1, 1'b1);
				1: configure(512, 1'b0, 1'b0);
				2: configure(1023, 1'b1, 1'b0);
				3: configure(256, 1'b0, 1'b1);
				default: configure($urandom_range(0, 1023), 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) != 0);
			endcase
			calm <= (p == 3);
			frame_pool[0] = '0;
			frame_pool[1] = 11'(FRAMES - 1);
			for (int i = 2; i < 8; i++)
				frame_pool[i] = 11'($urandom_range(0, FRAMES - 1));
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				if ($urandom_range(0, 4) == 0) begin
					send_word(random_word(kind_t'($urandom_range(0, 3)), pick_frame()));
				end else begin
					f = pick_frame();
					if ($urandom_range(0, 2) == 0)
						send_word(random_word(KIND_LOAD, f));
					repeat ($urandom_range(0, 2)) begin
						mix_kind = $urandom_range(0, 1) ? KIND_MIX16 : KIND_MIX8;
						send_word(random_word(mix_kind, f));
					end
					repeat ($urandom_range(1, 2))
						send_word(random_word(KIND_DRAIN, f));
				end
			end
			settle();
		end

		// stereo drain sweep: output held off so the block backs up, and a full
		// pause halfway
		calm <= 1'b0;
		configure($urandom_range(0, 1023), 1'($urandom_range(0, 1)), 1'b1);
		hold_tog <= ~hold_tog;
		for (int i = 0; i < SWEEP_WORDS; i++) begin
			if (i == SWEEP_WORDS / 2)
				settle();
			send_word(random_word(KIND_DRAIN, pick_frame()));
		end
		settle();

		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
